@@ design/lps_pkg.sv @@
// shared types, codes and constants of the link probe sequencer
package lps_pkg;

    localparam int DEF_STEP_COUNT    = 12;
    localparam int DEF_CAPTURE_DEPTH = 256;

    localparam logic [15:0] RST_INITIAL_DELAY   = 16'd150;
    localparam logic [15:0] RST_RESPONSE_WINDOW = 16'd800;
    localparam logic [15:0] RST_INTER_STEP      = 16'd120;
    localparam logic [3:0]  RST_STANDARD_LAST   = 4'd7;

    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [15:0] OFFSET_UNSET = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_INITIAL_DELAY   = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_WINDOW = 2'd1;
    localparam logic [1:0] CFG_INTER_STEP      = 2'd2;
    localparam logic [1:0] CFG_STANDARD_LAST   = 2'd3;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_RX_BYTE   = 3'd1,
        CMD_START     = 3'd2,
        CMD_READ_STEP = 3'd3,
        CMD_READ_BYTE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_SEND     = 2'd1,
        EV_FINISHED = 2'd2,
        EV_READ     = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_SEND = 2'd1,
        PH_WINDOW    = 2'd2,
        PH_DONE      = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] initial_delay_ms;
        logic [15:0] response_window_ms;
        logic [15:0] inter_step_ms;
        logic [3:0]  standard_last_step;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [3:0]  send_step;
        logic        done_res;
        logic        found_reply;
        logic [3:0]  first_reply_step;
        logic [3:0]  steps_sent;
        logic [15:0] bytes_total;
        logic [8:0]  bytes_stored;
        logic [15:0] step_byte_count;
        logic [15:0] step_first_offset;
        logic        rd_ok;
    } t_result;

endpackage

@@ design/lps_capture_mem.sv @@
// capture store: one write port, one registered read port
module lps_capture_mem #(
    parameter int DEPTH = lps_pkg::DEF_CAPTURE_DEPTH,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/lps_core.sv @@
// probe state machine, counters and per-step records
module lps_core #(
    parameter int STEP_COUNT    = lps_pkg::DEF_STEP_COUNT,
    parameter int CAPTURE_DEPTH = lps_pkg::DEF_CAPTURE_DEPTH,
    parameter int AW            = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [2:0]       i_cmd,
    input  logic [7:0]       i_idx,
    input  lps_pkg::t_cfg    i_cfg,
    output lps_pkg::t_result o_res,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr
);

    localparam int SIW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
    localparam int CW  = $clog2(CAPTURE_DEPTH + 1);
    localparam logic [3:0]    STEP_LIM  = 4'(STEP_COUNT);
    localparam logic [7:0]    STEP_LIM8 = 8'(STEP_COUNT);
    localparam logic [CW-1:0] DEPTH_C   = CW'(CAPTURE_DEPTH);
    localparam logic [15:0]   DEPTH_16  = 16'(CAPTURE_DEPTH);

    lps_pkg::t_phase r_phase, n_phase;
    logic [15:0]   r_countdown, n_countdown;
    logic [3:0]    r_next_step, n_next_step;
    logic [3:0]    r_last_sent, n_last_sent;
    logic [15:0]   r_total, n_total;
    logic [CW-1:0] r_stored, n_stored;
    logic [3:0]    r_first_reply, n_first_reply;
    logic          r_finished, n_finished;
    logic          r_found, n_found;
    // count and offset of the step last requested, mirrored into the tables
    logic [15:0]   r_cur_count, n_cur_count;
    logic [15:0]   r_cur_offset, n_cur_offset;
    logic [15:0]   r_step_count  [STEP_COUNT];
    logic [15:0]   r_step_offset [STEP_COUNT];

    logic        clear_run;
    logic        step_wr;
    logic        active;
    logic [15:0] cd_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lps_pkg::PH_IDLE;
            r_countdown   <= 16'd0;
            r_next_step   <= 4'd0;
            r_last_sent   <= STEP_LIM;
            r_total       <= 16'd0;
            r_stored      <= '0;
            r_first_reply <= STEP_LIM;
            r_finished    <= 1'b0;
            r_found       <= 1'b0;
            r_cur_count   <= 16'd0;
            r_cur_offset  <= lps_pkg::OFFSET_UNSET;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_countdown   <= n_countdown;
            r_next_step   <= n_next_step;
            r_last_sent   <= n_last_sent;
            r_total       <= n_total;
            r_stored      <= n_stored;
            r_first_reply <= n_first_reply;
            r_finished    <= n_finished;
            r_found       <= n_found;
            r_cur_count   <= n_cur_count;
            r_cur_offset  <= n_cur_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && clear_run)) begin
            for (int i = 0; i < STEP_COUNT; i++) begin
                r_step_count[i]  <= 16'd0;
                r_step_offset[i] <= lps_pkg::OFFSET_UNSET;
            end
        end else if (i_fire && step_wr) begin
            r_step_count[r_last_sent[SIW-1:0]]  <= n_cur_count;
            r_step_offset[r_last_sent[SIW-1:0]] <= n_cur_offset;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_countdown   = r_countdown;
        n_next_step   = r_next_step;
        n_last_sent   = r_last_sent;
        n_total       = r_total;
        n_stored      = r_stored;
        n_first_reply = r_first_reply;
        n_finished    = r_finished;
        n_found       = r_found;
        n_cur_count   = r_cur_count;
        n_cur_offset  = r_cur_offset;
        clear_run     = 1'b0;
        step_wr       = 1'b0;
        o_wr_en       = 1'b0;
        cd_dec        = (r_countdown != 16'd0) ? r_countdown - 16'd1 : 16'd0;
        active        = (r_phase == lps_pkg::PH_WAIT_SEND) || (r_phase == lps_pkg::PH_WINDOW);

        o_res                   = '0;
        o_res.event_res         = lps_pkg::EV_NONE;
        o_res.step_first_offset = lps_pkg::OFFSET_UNSET;

        case (lps_pkg::t_cmd'(i_cmd))
            lps_pkg::CMD_TICK: begin
                if (active) begin
                    n_countdown = cd_dec;
                    if (cd_dec == 16'd0) begin
                        if (r_phase == lps_pkg::PH_WAIT_SEND) begin
                            if (r_next_step >= STEP_LIM) begin
                                n_phase         = lps_pkg::PH_DONE;
                                n_finished      = 1'b1;
                                n_found         = (r_total != 16'd0);
                                o_res.event_res = lps_pkg::EV_FINISHED;
                            end else begin
                                o_res.send_step = r_next_step;
                                o_res.event_res = lps_pkg::EV_SEND;
                                n_last_sent     = r_next_step;
                                n_next_step     = r_next_step + 4'd1;
                                n_phase         = lps_pkg::PH_WINDOW;
                                n_countdown     = i_cfg.response_window_ms;
                                n_cur_count     = 16'd0;
                            end
                        end else if ((r_last_sent < STEP_LIM) &&
                                     (((r_last_sent == i_cfg.standard_last_step) &&
                                       (r_total != 16'd0)) ||
                                      ((r_last_sent > i_cfg.standard_last_step) &&
                                       (r_cur_count != 16'd0)))) begin
                            n_phase         = lps_pkg::PH_DONE;
                            n_finished      = 1'b1;
                            n_found         = 1'b1;
                            o_res.event_res = lps_pkg::EV_FINISHED;
                        end else begin
                            n_phase     = lps_pkg::PH_WAIT_SEND;
                            n_countdown = i_cfg.inter_step_ms;
                        end
                    end
                end
            end
            lps_pkg::CMD_RX_BYTE: begin
                if (active) begin
                    if (r_total != lps_pkg::COUNT_MAX) begin
                        n_total = r_total + 16'd1;
                    end
                    if (r_last_sent < STEP_LIM) begin
                        step_wr = 1'b1;
                        if (r_cur_count == 16'd0) begin
                            n_cur_offset = 16'(r_stored);
                        end
                        if (r_cur_count != lps_pkg::COUNT_MAX) begin
                            n_cur_count = r_cur_count + 16'd1;
                        end
                        if (r_first_reply >= STEP_LIM) begin
                            n_first_reply = r_last_sent;
                        end
                    end
                    // bytes past the store's capacity are counted, not kept
                    if (r_stored < DEPTH_C) begin
                        o_wr_en  = 1'b1;
                        n_stored = r_stored + CW'(1);
                    end
                end
            end
            lps_pkg::CMD_START: begin
                clear_run     = 1'b1;
                n_phase       = lps_pkg::PH_WAIT_SEND;
                n_countdown   = i_cfg.initial_delay_ms;
                n_next_step   = 4'd0;
                n_last_sent   = STEP_LIM;
                n_total       = 16'd0;
                n_stored      = '0;
                n_first_reply = STEP_LIM;
                n_finished    = 1'b0;
                n_found       = 1'b0;
                n_cur_count   = 16'd0;
                n_cur_offset  = lps_pkg::OFFSET_UNSET;
            end
            lps_pkg::CMD_READ_STEP: begin
                o_res.event_res = lps_pkg::EV_READ;
                if (i_idx < STEP_LIM8) begin
                    o_res.step_byte_count   = r_step_count[i_idx[SIW-1:0]];
                    o_res.step_first_offset = r_step_offset[i_idx[SIW-1:0]];
                end
            end
            lps_pkg::CMD_READ_BYTE: begin
                o_res.event_res = lps_pkg::EV_READ;
                o_res.rd_ok     = (16'(i_idx) < 16'(r_stored)) && (16'(i_idx) < DEPTH_16);
            end
            default: begin
            end
        endcase

        o_res.done_res         = n_finished;
        o_res.found_reply      = n_found;
        o_res.first_reply_step = n_first_reply;
        o_res.steps_sent       = n_next_step;
        o_res.bytes_total      = n_total;
        o_res.bytes_stored     = 9'(n_stored);
    end

    assign o_wr_addr = AW'(r_stored);

endmodule

@@ design/link_probe_sequencer.sv @@
// top level of the link probe sequencer: channels, config registers, result register
//
//   channel   direction  handshake               payload
//   in        to block   i_in_valid/o_in_stall   i_command, i_rx_byte, i_index
//   out       from block o_out_valid/i_out_stall o_event_res ... o_captured_byte
//   cfg       to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one transaction per cycle in and out unless the out channel stalls; results are registered
// the input register feeds the state update and the capture store read, whose
// registered read data joins the result register
// synchronous active-low reset; no clearing pass, the capture store is left as is
// a stalled result holds in the result register while one more input waits in the
// input register; o_in_stall rises only when both are full
module link_probe_sequencer #(
    parameter int STEP_COUNT    = lps_pkg::DEF_STEP_COUNT,
    parameter int CAPTURE_DEPTH = lps_pkg::DEF_CAPTURE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [3:0]  o_send_step,
    output logic        o_done_res,
    output logic        o_found_reply,
    output logic [3:0]  o_first_reply_step,
    output logic [3:0]  o_steps_sent,
    output logic [15:0] o_bytes_total,
    output logic [8:0]  o_bytes_stored,
    output logic [15:0] o_step_byte_count,
    output logic [15:0] o_step_first_offset,
    output logic [7:0]  o_captured_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

    lps_pkg::t_cfg    r_cfg;
    lps_pkg::t_result core_res;
    lps_pkg::t_result r_res;

    logic          r_in_valid;
    logic [2:0]    r_command;
    logic [7:0]    r_rx_byte;
    logic [7:0]    r_index;
    logic          r_out_valid;
    logic          advance;
    logic          fire;
    logic          in_accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay_ms   <= lps_pkg::RST_INITIAL_DELAY;
            r_cfg.response_window_ms <= lps_pkg::RST_RESPONSE_WINDOW;
            r_cfg.inter_step_ms      <= lps_pkg::RST_INTER_STEP;
            r_cfg.standard_last_step <= lps_pkg::RST_STANDARD_LAST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lps_pkg::CFG_INITIAL_DELAY:   r_cfg.initial_delay_ms   <= i_cfg_data;
                lps_pkg::CFG_RESPONSE_WINDOW: r_cfg.response_window_ms <= i_cfg_data;
                lps_pkg::CFG_INTER_STEP:      r_cfg.inter_step_ms      <= i_cfg_data;
                lps_pkg::CFG_STANDARD_LAST:   r_cfg.standard_last_step <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command <= i_command;
            r_rx_byte <= i_rx_byte;
            r_index   <= i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    lps_core #(
        .STEP_COUNT    (STEP_COUNT),
        .CAPTURE_DEPTH (CAPTURE_DEPTH),
        .AW            (AW)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_cmd     (r_command),
        .i_idx     (r_index),
        .i_cfg     (r_cfg),
        .o_res     (core_res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr)
    );

    lps_capture_mem #(
        .DEPTH (CAPTURE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (fire && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_rx_byte),
        .i_rd_en   (fire),
        .i_rd_addr (AW'(r_index)),
        .o_rd_data (rd_data)
    );

    assign o_out_valid         = r_out_valid;
    assign o_event_res         = r_res.event_res;
    assign o_send_step         = r_res.send_step;
    assign o_done_res          = r_res.done_res;
    assign o_found_reply       = r_res.found_reply;
    assign o_first_reply_step  = r_res.first_reply_step;
    assign o_steps_sent        = r_res.steps_sent;
    assign o_bytes_total       = r_res.bytes_total;
    assign o_bytes_stored      = r_res.bytes_stored;
    assign o_step_byte_count   = r_res.step_byte_count;
    assign o_step_first_offset = r_res.step_first_offset;
    assign o_captured_byte     = r_res.rd_ok ? rd_data : 8'h00;

endmodule

@@ design/lps_checker.sv @@
// port-level checks of the link probe sequencer and their binding
module lps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_event_res,
    input logic [3:0] o_send_step,
    input logic [3:0] o_steps_sent,
    input logic       o_done_res,
    input logic       o_found_reply
);

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a step request is counted in the same transaction
    a_send_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == lps_pkg::EV_SEND) |->
            ((o_send_step + 4'd1) == o_steps_sent) && !o_done_res)
        else $error("step request not counted");

    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == lps_pkg::EV_FINISHED) |-> o_done_res)
        else $error("finish without done");

    a_found_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found_reply |-> o_done_res)
        else $error("reply found before finish");

endmodule

bind link_probe_sequencer lps_checker u_lps_checker (.*);
